FILE: src/srfp_pkg.sv
// Package with the shared types and constants of the sensor reply frame parser.
package srfp_pkg;

    localparam int ByteWidth   = 8;
    localparam int PosWidth    = 4;
    localparam int ValueWidth  = 17;
    localparam int StatusWidth = 2;

    localparam logic [ByteWidth-1:0] SyncByte0  = 8'h55;
    localparam logic [ByteWidth-1:0] SyncByte1  = 8'hAA;
    localparam logic [ByteWidth-1:0] LengthByte = 8'h02;
    localparam logic [ByteWidth-1:0] CmdDist    = 8'h02;
    localparam logic [ByteWidth-1:0] CmdTemp    = 8'h03;

    // Byte positions inside the reply frame.
    localparam logic [PosWidth-1:0] PosSync0    = 4'd0;
    localparam logic [PosWidth-1:0] PosSync1    = 4'd1;
    localparam logic [PosWidth-1:0] PosAddr     = 4'd2;
    localparam logic [PosWidth-1:0] PosLength   = 4'd3;
    localparam logic [PosWidth-1:0] PosCmd      = 4'd4;
    localparam logic [PosWidth-1:0] PosHigh     = 4'd5;
    localparam logic [PosWidth-1:0] PosLow      = 4'd6;
    localparam logic [PosWidth-1:0] PosChecksum = 4'd7;
    localparam logic [PosWidth-1:0] PosIdle     = 4'd8;

    typedef enum logic [StatusWidth-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_HEADER   = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [ByteWidth-1:0] rx_byte;
        logic                 frame_start;
    } beat_t;

    typedef struct packed {
        logic                         reading_kind;
        logic signed [ValueWidth-1:0] reading_value;
        frame_status_t                frame_status;
    } result_t;

endpackage

FILE: src/srfp_in_stage.sv
// Input register stage of the sensor reply frame parser.
module srfp_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  srfp_pkg::beat_t in_beat,
    output logic           beat_valid,
    input  logic           beat_take,
    output srfp_pkg::beat_t beat
);
    import srfp_pkg::*;

    logic  valid_reg, valid_next;
    beat_t beat_reg;

    assign in_ready   = !valid_reg || beat_take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

FILE: src/srfp_parser.sv
// Frame state, header and checksum checks, and value decode of one beat.
module srfp_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [srfp_pkg::ByteWidth-1:0]     cfg_wdata,
    input  logic                               beat_take,
    input  srfp_pkg::beat_t                    beat,
    output logic                               res_valid,
    output srfp_pkg::result_t                  res
);
    import srfp_pkg::*;

    logic [ByteWidth-1:0] addr_reg;
    logic [PosWidth-1:0]  pos_reg, pos_next;
    logic [ByteWidth-1:0] sum_reg, sum_next;
    logic                 good_reg, good_next;
    logic                 temp_reg, temp_next;
    logic [ByteWidth-1:0] high_reg, high_next;
    logic [ByteWidth-1:0] low_reg, low_next;

    logic [PosWidth-1:0]  pos_cur;
    logic [ByteWidth-1:0] sum_cur;
    logic                 good_cur;
    logic                 temp_cur;
    logic [ByteWidth-1:0] b;
    logic [11:0]          magnitude;
    logic signed [ValueWidth-1:0] temp_value;
    logic signed [ValueWidth-1:0] dist_value;

    assign b = beat.rx_byte;

    // A start flag opens a new frame on the very beat that carries it.
    assign pos_cur  = beat.frame_start ? PosSync0 : pos_reg;
    assign sum_cur  = beat.frame_start ? '0 : sum_reg;
    assign good_cur = beat.frame_start ? 1'b1 : good_reg;
    assign temp_cur = beat.frame_start ? 1'b0 : temp_reg;

    assign magnitude  = {high_reg[3:0], low_reg};
    assign dist_value = $signed({1'b0, high_reg, low_reg});
    assign temp_value = (high_reg[7:4] != 4'd0)
                        ? -$signed({5'd0, magnitude})
                        : $signed({5'd0, magnitude});

    always_comb
    begin
        pos_next  = pos_cur;
        sum_next  = sum_cur;
        good_next = good_cur;
        temp_next = temp_cur;
        high_next = beat.frame_start ? '0 : high_reg;
        low_next  = beat.frame_start ? '0 : low_reg;
        res_valid = 1'b0;
        res.reading_kind  = 1'b0;
        res.reading_value = '0;
        res.frame_status  = STATUS_OK;

        if (pos_cur < PosIdle)
        begin
            case (pos_cur)
                PosSync0:  if (b != SyncByte0)  good_next = 1'b0;
                PosSync1:  if (b != SyncByte1)  good_next = 1'b0;
                PosAddr:   if (b != addr_reg)   good_next = 1'b0;
                PosLength: if (b != LengthByte) good_next = 1'b0;
                PosCmd:
                begin
                    if (b == CmdTemp)
                    begin
                        temp_next = 1'b1;
                    end
                    else if (b != CmdDist)
                    begin
                        good_next = 1'b0;
                    end
                end
                PosHigh:   high_next = b;
                PosLow:    low_next  = b;
                default:   ;
            endcase

            if (pos_cur != PosChecksum)
            begin
                sum_next = sum_cur + b;
                pos_next = pos_cur + 4'd1;
            end
            else
            begin
                pos_next  = PosIdle;
                res_valid = 1'b1;
                if (!good_cur)
                begin
                    res.frame_status = STATUS_HEADER;
                end
                else
                begin
                    res.reading_kind = temp_cur;
                    if (b != sum_cur)
                    begin
                        res.frame_status = STATUS_CHECKSUM;
                    end
                    else
                    begin
                        res.reading_value = temp_cur ? temp_value : dist_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            pos_reg  <= PosIdle;
            sum_reg  <= '0;
            good_reg <= 1'b1;
            temp_reg <= 1'b0;
            high_reg <= '0;
            low_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                addr_reg <= cfg_wdata;
            end
            if (beat_take)
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                good_reg <= good_next;
                temp_reg <= temp_next;
                high_reg <= high_next;
                low_reg  <= low_next;
            end
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PosIdle)
        else $error("frame position out of range");

    a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_take && res_valid) |=> (pos_reg == PosIdle))
        else $error("frame not closed after result");

    a_header_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_status == STATUS_HEADER)
        |-> (!res.reading_kind && res.reading_value == '0))
        else $error("header mismatch result carries data");

    a_result_only_at_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!beat.frame_start && pos_reg == PosChecksum))
        else $error("result outside checksum byte");

endmodule

FILE: src/srfp_out_stage.sv
// Output result register of the sensor reply frame parser.
module srfp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  srfp_pkg::result_t res,
    output logic              out_ready,
    output logic              out_valid,
    input  logic              out_take,
    output srfp_pkg::result_t out_res
);
    import srfp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_ready = !valid_reg || out_take;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: src/sensor_reply_frame_parser_unit.sv
// Top level of the sensor reply frame parser: input register, parser, result register.
// m_tvalid rises when the result register takes the result of the checksum byte.
// Throughput: one received byte per cycle, set by the single-pass parser between the
// input and result registers; a result held while m_tready is low stalls the parser.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the address
// to zero and leaves the parser idle until a beat with the start flag arrives.
module sensor_reply_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] reading_value, [18:17] frame_status, rest zero
    output logic        m_tuser    // [0] reading_kind
);
    import srfp_pkg::*;

    beat_t   in_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    beat_take;
    logic    res_valid;
    result_t res;
    logic    out_ready;
    result_t out_res;

    assign in_beat.rx_byte     = s_tdata;
    assign in_beat.frame_start = s_tuser;

    // The parser state moves only when the result register can take a result.
    assign beat_take = beat_valid && out_ready;

    srfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_beat    (in_beat),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .beat       (beat)
    );

    srfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .beat_take (beat_take),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    srfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid && beat_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (m_tvalid),
        .out_take  (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.frame_status, out_res.reading_value};
    assign m_tuser = out_res.reading_kind;

endmodule

FILE: verif/sensor_reply_frame_parser_unit_tb.sv
// Self-checking testbench for the sensor reply frame parser: byte stream in, readings out.
`timescale 1ns / 100ps

module sensor_reply_frame_parser_unit_tb;

    import srfp_pkg::*;

    // Tracks the frame state the way the parser should and holds the readings still owed.
    class reply_frame_tracker;
        logic [ByteWidth-1:0] address;
        logic [PosWidth-1:0]  position;
        logic [ByteWidth-1:0] sum;
        bit                   header_ok;
        bit                   is_temp;
        logic [ByteWidth-1:0] high_byte;
        logic [ByteWidth-1:0] low_byte;
        result_t              expected_readings[$];
        int                   mismatches;

        function new();
            address    = '0;
            position   = PosIdle;
            sum        = '0;
            header_ok  = 1'b1;
            is_temp    = 1'b0;
            high_byte  = '0;
            low_byte   = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_readings.size();
        endfunction

        function void take_byte(logic [ByteWidth-1:0] b, logic start);
            result_t     r;
            logic [11:0] mag;
            if (start)
            begin
                position  = PosSync0;
                sum       = '0;
                header_ok = 1'b1;
                is_temp   = 1'b0;
                high_byte = '0;
                low_byte  = '0;
            end
            if (position >= PosIdle)
                return;
            case (position)
                PosSync0:  if (b != SyncByte0) header_ok = 1'b0;
                PosSync1:  if (b != SyncByte1) header_ok = 1'b0;
                PosAddr:   if (b != address) header_ok = 1'b0;
                PosLength: if (b != LengthByte) header_ok = 1'b0;
                PosCmd:
                begin
                    if (b == CmdTemp)
                        is_temp = 1'b1;
                    else if (b != CmdDist)
                        header_ok = 1'b0;
                end
                PosHigh:   high_byte = b;
                PosLow:    low_byte = b;
                default:   ;
            endcase
            if (position < PosChecksum)
            begin
                sum      = sum + b;
                position = position + 1'b1;
                return;
            end
            position        = PosIdle;
            r.reading_kind  = 1'b0;
            r.reading_value = '0;
            if (!header_ok)
                r.frame_status = STATUS_HEADER;
            else
            begin
                r.reading_kind = is_temp;
                if (b != sum)
                    r.frame_status = STATUS_CHECKSUM;
                else
                begin
                    r.frame_status = STATUS_OK;
                    if (is_temp)
                    begin
                        // Low nibble of the high byte extends the magnitude; any bit in
                        // the high nibble marks the reading as below zero.
                        mag = {high_byte[3:0], low_byte};
                        if (high_byte[7:4] != 4'd0)
                            r.reading_value = -{5'd0, mag};
                        else
                            r.reading_value = {5'd0, mag};
                    end
                    else
                        r.reading_value = {1'b0, high_byte, low_byte};
                end
            end
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic kind, logic [23:0] data);
            result_t r;
            if (expected_readings.size() == 0)
            begin
                $error("reading with none expected: kind %0d, data %h", kind, data);
                mismatches++;
                return;
            end
            r = expected_readings.pop_front();
            if (kind !== r.reading_kind)
            begin
                $error("reading_kind: expected %0d, actual %0d", r.reading_kind, kind);
                mismatches++;
            end
            if (data[16:0] !== r.reading_value)
            begin
                $error("reading_value: expected %0d, actual %0d",
                       r.reading_value, $signed(data[16:0]));
                mismatches++;
            end
            if (data[18:17] !== r.frame_status)
            begin
                $error("frame_status: expected %0d, actual %0d", r.frame_status, data[18:17]);
                mismatches++;
            end
            if (data[23:19] !== 5'd0)
            begin
                $error("m_tdata padding: expected 0, actual %h", data[23:19]);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    reply_frame_tracker tracker = new();
    bit sender_gaps = 1'b1;
    bit sink_gaps   = 1'b1;
    int beats_sent  = 0;

    sensor_reply_frame_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Reading side: check each accepted beat, then choose the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_reading(m_tuser, m_tdata);
        m_tready <= !sink_gaps || ($urandom_range(99) >= 27);
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic start);
        while (sender_gaps && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_byte(b, start);
        beats_sent++;
    endtask

    // Sends the first length bytes of a frame; the checksum is the true sum xor flip.
    task automatic send_frame(input logic [7:0] s0, s1, adr, len, cmd, hi, lo, flip,
                              input int length);
        logic [7:0] bytes [8];
        logic [7:0] sum;
        int         k;
        bytes = '{s0, s1, adr, len, cmd, hi, lo, 8'h00};
        sum = '0;
        for (k = 0; k < 7; k++)
            sum = sum + bytes[k];
        bytes[7] = sum ^ flip;
        for (k = 0; k < length; k++)
            send_beat(bytes[k], k == 0);
    endtask

    function automatic logic [7:0] value_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 8'h00;
        if (pick < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Mostly well-formed frames; now and then a bad header field, a bad sum, a cut frame
    // that the next start flag restarts, or stray bytes between frames.
    task automatic send_random_frame();
        logic [7:0] s0, s1, adr, len, cmd, flip;
        int         pick;
        int         length;
        s0   = ($urandom_range(99) < 3) ? 8'($urandom) : SyncByte0;
        s1   = ($urandom_range(99) < 3) ? 8'($urandom) : SyncByte1;
        adr  = ($urandom_range(99) < 5) ? 8'($urandom) : tracker.address;
        len  = ($urandom_range(99) < 3) ? 8'($urandom) : LengthByte;
        pick = $urandom_range(99);
        cmd  = (pick < 46) ? CmdDist : (pick < 92) ? CmdTemp : 8'($urandom);
        flip = ($urandom_range(99) < 6) ? 8'($urandom_range(1, 255)) : 8'h00;
        length = ($urandom_range(99) < 5) ? $urandom_range(1, 7) : 8;
        send_frame(s0, s1, adr, len, cmd, value_byte(), value_byte(), flip, length);
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 3))
                send_beat(8'($urandom), $urandom_range(99) < 10);
        end
    endtask

    task automatic wait_for_readings();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        wait_for_readings();
        // A cut frame leaves bytes in flight that owe no reading; let them settle.
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.address = a;
    endtask

    initial
    begin
        int  phase;
        int  phase_start;
        bit  paused;
        logic [7:0] phase_address;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset address of zero.
        send_beat(8'h00, 1'b0);
        send_frame(SyncByte0, SyncByte1, 8'h00, LengthByte, CmdTemp, 8'h12, 8'h34, 8'h00, 3);
        send_frame(SyncByte0, SyncByte1, 8'h00, LengthByte, CmdTemp, 8'hFF, 8'hFF, 8'h00, 8);
        send_frame(SyncByte0, SyncByte1, 8'h00, LengthByte, CmdDist, 8'hFF, 8'hFF, 8'h01, 8);
        send_frame(8'h54, SyncByte1, 8'h00, LengthByte, CmdDist, 8'h00, 8'h00, 8'h80, 8);
        send_beat(8'hA5, 1'b0);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       phase_address = 8'hFF;
                2:       phase_address = 8'($urandom);
                3:       phase_address = 8'h00;
                default: phase_address = tracker.address;
            endcase
            if (phase > 0)
                write_address(phase_address);
            // Phase two runs with neither side holding back.
            sender_gaps = (phase != 2);
            sink_gaps   = (phase != 2);
            phase_start = beats_sent;
            while (beats_sent - phase_start < 400)
            begin
                if (phase == 1 && !paused && beats_sent - phase_start > 200)
                begin
                    wait_for_readings();
                    paused = 1'b1;
                end
                send_random_frame();
            end
        end

        wait_for_readings();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/srfp_pkg.sv
src/srfp_in_stage.sv
src/srfp_parser.sv
src/srfp_out_stage.sv
src/sensor_reply_frame_parser_unit.sv
verif/sensor_reply_frame_parser_unit_tb.sv
